// ===== hdl/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

    localparam int WORD_W      = 32;
    localparam int KIND_W      = 3;
    localparam int COUNT_OUT_W = 5;

    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK       = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_OLD,
        S_UPDATE,
        S_RD_NEW,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic latch;
        logic rd;
        logic update;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/deq_req_if.sv =====
`default_nettype none

interface deq_req_if;
    logic                                valid;
    logic                                ready;
    logic        [deq_pkg::KIND_W-1:0]   kind;
    logic signed [deq_pkg::WORD_W-1:0]   push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/deq_rsp_if.sv =====
`default_nettype none

interface deq_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [deq_pkg::WORD_W-1:0]       popped_value;
    logic                                    fail;
    logic        [deq_pkg::COUNT_OUT_W-1:0]  entry_count;
    logic                                    is_empty;
    logic signed [deq_pkg::WORD_W-1:0]       front_word;
    logic signed [deq_pkg::WORD_W-1:0]       back_word;

    modport source (
        output valid, output popped_value, output fail, output entry_count,
        output is_empty, output front_word, output back_word, input ready
    );
    modport sink (
        input valid, input popped_value, input fail, input entry_count,
        input is_empty, input front_word, input back_word, output ready
    );
endinterface

`default_nettype wire

// ===== hdl/double_ended_queue_unit.sv =====
// Bounded double-ended queue of DEPTH signed 32-bit words kept in a ring buffer.
// Each request transfer carries one operation (push front, push back, pop front,
// pop back, or peek; unused codes act as a peek) and yields exactly one response
// transfer with the popped word, a fail flag, the count, an empty flag, and the
// front and back words after the operation (-1 when empty). A push into a full
// queue is dropped and flagged; a pop from an empty queue returns -1 and fails.
// The response becomes valid when its register is loaded at the end of the
// controller sequence of latch, old-end read, update, new-end read and load
// through the two registered read ports of the word memory. The next request is
// taken in the cycle after the response register is loaded, so a new request is
// not taken before the last operation is through, and the load waits while an earlier
// response has not yet been transferred. Storage is not cleared at reset and needs no clearing pass.
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    deq_req_if.sink     i_req,
    deq_rsp_if.source   o_rsp
);
    import deq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_req_ready;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_kind         (i_req.kind),
        .i_push_value   (i_req.push_value),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_popped_value (o_rsp.popped_value),
        .o_fail         (o_rsp.fail),
        .o_entry_count  (o_rsp.entry_count),
        .o_is_empty     (o_rsp.is_empty),
        .o_front_word   (o_rsp.front_word),
        .o_back_word    (o_rsp.back_word)
    );

    assign i_req.ready = w_req_ready;

endmodule

`default_nettype wire

// ===== hdl/deq_ctrl.sv =====
`default_nettype none

module deq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire deq_pkg::t_sts i_sts,
    output deq_pkg::t_cmd      o_cmd
);
    import deq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_RD_OLD;
                end
            end
            S_RD_OLD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_RD_NEW;
            end
            S_RD_NEW: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/deq_datapath.sv =====
`default_nettype none

module deq_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire deq_pkg::t_cmd                      i_cmd,
    output deq_pkg::t_sts                           o_sts,
    input  wire logic        [deq_pkg::KIND_W-1:0]  i_kind,
    input  wire logic signed [deq_pkg::WORD_W-1:0]  i_push_value,
    input  wire logic                               i_rsp_ready,
    output logic                                    o_rsp_valid,
    output logic signed [deq_pkg::WORD_W-1:0]       o_popped_value,
    output logic                                    o_fail,
    output logic        [deq_pkg::COUNT_OUT_W-1:0]  o_entry_count,
    output logic                                    o_is_empty,
    output logic signed [deq_pkg::WORD_W-1:0]       o_front_word,
    output logic signed [deq_pkg::WORD_W-1:0]       o_back_word
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [AW:0]   WRAP = (AW + 1)'(DEPTH);

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [AW-1:0] offset);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= WRAP) begin
            sum = sum - WRAP;
        end
        return sum[AW-1:0];
    endfunction

    logic [WORD_W-1:0] r_mem [DEPTH];

    logic [KIND_W-1:0] r_kind;
    logic [WORD_W-1:0] r_word;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     n_head;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [WORD_W-1:0] r_popped;
    logic [WORD_W-1:0] n_popped;
    logic              r_fail;
    logic              n_fail;
    logic [WORD_W-1:0] r_rd_front;
    logic [WORD_W-1:0] r_rd_back;
    logic              r_out_valid;

    logic              w_empty;
    logic              w_full;
    logic [AW-1:0]     w_tail;
    logic [AW-1:0]     w_next_slot;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [31:0]       w_count_ext;

    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == FULL_COUNT);
    assign w_tail      = slot_of(r_head, w_empty ? '0 : AW'(r_count - 1'b1));
    assign w_next_slot = slot_of(r_head, AW'(r_count));
    assign w_count_ext = 32'(r_count);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_popped  = r_popped;
        n_fail    = r_fail;
        w_wr_en   = 1'b0;
        w_wr_addr = w_next_slot;
        if (i_cmd.update) begin
            n_popped = '0;
            n_fail   = 1'b0;
            unique case (r_kind)
                KIND_PUSH_FRONT: begin
                    if (w_full) begin
                        n_fail = 1'b1;
                    end else begin
                        n_head    = (r_head == '0) ? LAST_SLOT : r_head - 1'b1;
                        w_wr_en   = 1'b1;
                        w_wr_addr = n_head;
                        n_count   = r_count + 1'b1;
                    end
                end
                KIND_PUSH_BACK: begin
                    if (w_full) begin
                        n_fail = 1'b1;
                    end else begin
                        w_wr_en = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                KIND_POP_FRONT: begin
                    if (w_empty) begin
                        n_fail   = 1'b1;
                        n_popped = EMPTY_WORD;
                    end else begin
                        n_popped = r_rd_front;
                        n_head   = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                        n_count  = r_count - 1'b1;
                    end
                end
                KIND_POP_BACK: begin
                    if (w_empty) begin
                        n_fail   = 1'b1;
                        n_popped = EMPTY_WORD;
                    end else begin
                        n_popped = r_rd_back;
                        n_count  = r_count - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= r_word;
        end
        if (i_cmd.rd) begin
            r_rd_front <= r_mem[r_head];
            r_rd_back  <= r_mem[w_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped <= n_popped;
        r_fail   <= n_fail;
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_word <= i_push_value;
        end
        if (i_cmd.load) begin
            o_popped_value <= r_popped;
            o_fail         <= r_fail;
            o_entry_count  <= w_count_ext[COUNT_OUT_W-1:0];
            o_is_empty     <= w_empty;
            o_front_word   <= w_empty ? EMPTY_WORD : r_rd_front;
            o_back_word    <= w_empty ? EMPTY_WORD : r_rd_back;
        end
    end

    assign o_rsp_valid    = r_out_valid;
    assign o_sts.out_busy = r_out_valid && !i_rsp_ready;

endmodule

`default_nettype wire

// ===== hdl/deq_checker.sv =====
`default_nettype none

module deq_checker #(
    parameter int DEPTH = 16
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_rsp_valid,
    input wire logic                               i_rsp_ready,
    input wire logic signed [deq_pkg::WORD_W-1:0]  i_popped_value,
    input wire logic                               i_fail,
    input wire logic [deq_pkg::COUNT_OUT_W-1:0]    i_entry_count,
    input wire logic                               i_is_empty,
    input wire logic signed [deq_pkg::WORD_W-1:0]  i_front_word,
    input wire logic signed [deq_pkg::WORD_W-1:0]  i_back_word
);
    import deq_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_popped_value)
            && $stable(i_fail) && $stable(i_entry_count) && $stable(i_front_word))
        else $error("Response changed while stalled.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_is_empty == (i_entry_count == '0)) || (DEPTH > 31))
        else $error("Empty flag disagrees with the count.");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_is_empty |-> (i_front_word == EMPTY_WORD)
            && (i_back_word == EMPTY_WORD))
        else $error("Empty queue shows end words other than all ones.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (DEPTH > 31) || (32'(i_entry_count) <= DEPTH))
        else $error("Count exceeds the queue depth.");

    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_fail |-> (i_popped_value == '0)
            || (i_popped_value == EMPTY_WORD))
        else $error("Failed operation returned a stored word.");

endmodule

bind double_ended_queue_unit deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_popped_value (o_rsp.popped_value),
    .i_fail         (o_rsp.fail),
    .i_entry_count  (o_rsp.entry_count),
    .i_is_empty     (o_rsp.is_empty),
    .i_front_word   (o_rsp.front_word),
    .i_back_word    (o_rsp.back_word)
);

`default_nettype wire
